// ===== rtl/lbc_pkg.sv =====
// Shared constants for the line clipper.
// Used by every module of the block; no dependencies.
package lbc_pkg;
	localparam logic [1:0] REG_MIN_X = 2'd0;
	localparam logic [1:0] REG_MIN_Y = 2'd1;
	localparam logic [1:0] REG_MAX_X = 2'd2;
	localparam logic [1:0] REG_MAX_Y = 2'd3;
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ENTER = 2'd1;
	localparam logic [1:0] KIND_EXIT = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;
	localparam int OUT_W = 20;
endpackage

// ===== rtl/lbc_edge_cell.sv =====
// One boundary test cell: ratio q/p by a pipelined divider row, then bound update.
// Depends on lbc_pkg.
module lbc_edge_cell #(
	parameter int CW = 16,
	parameter int UF = 16,
	parameter int LAT = 22
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW+1:0] p,
	input  logic signed [CW+1:0] q,
	input  logic                 in_ok,
	input  logic signed [UF+2:0] in_u1,
	input  logic signed [UF+2:0] in_u2,
	output logic                 out_ok,
	output logic signed [UF+2:0] out_u1,
	output logic signed [UF+2:0] out_u2
);
	import lbc_pkg::*;
	localparam int QW = CW + 2 + UF + 1;
	localparam int DW = CW + 2;
	localparam logic signed [UF+2:0] ONE = (UF+3)'(1) <<< UF;
	// Unsigned restoring division, one slice of floor or ceil of QW/LAT quotient bits per stage.
	logic [QW-1:0] num_s [0:LAT];
	logic [DW-1:0] den_s [0:LAT];
	logic [QW-1:0] quo_s [0:LAT];
	logic [DW:0]   rem_s [0:LAT];
	logic          neg_s [0:LAT];
	logic [1:0]    kind_s [0:LAT];
	logic          ok_s [0:LAT];
	logic signed [UF+2:0] u1_s [0:LAT];
	logic signed [UF+2:0] u2_s [0:LAT];
	logic signed [QW-1:0] n0;
	logic signed [DW-1:0] d0;
	always_comb begin
		n0 = QW'(q) <<< UF;
		d0 = DW'(p);
		if (p < 0) begin
			n0 = -n0;
			d0 = -d0;
		end
		num_s[0] = n0[QW-1] ? QW'(-n0) : QW'(n0);
		den_s[0] = d0;
		neg_s[0] = n0[QW-1];
		quo_s[0] = '0;
		rem_s[0] = '0;
		kind_s[0] = (p < 0) ? KIND_ENTER : (p > 0) ? KIND_EXIT :
			(q < 0) ? KIND_REJECT : KIND_NONE;
		ok_s[0] = in_ok;
		u1_s[0] = in_u1;
		u2_s[0] = in_u2;
	end
	for (genvar i = 0; i < LAT; i++) begin : g_st
		localparam int B = QW - 1 - (i * QW) / LAT;
		localparam int E = QW - 1 - (((i + 1) * QW) / LAT) + 1;
		logic [DW:0]   r;
		logic [QW-1:0] qq;
		always_comb begin
			r = rem_s[i];
			qq = quo_s[i];
			for (int b = B; b >= E; b--) begin
				r = {r[DW-1:0], num_s[i][b]};
				qq = qq << 1;
				if (r >= {1'b0, den_s[i]}) begin
					r = r - {1'b0, den_s[i]};
					qq[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= num_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= qq;
				rem_s[i+1] <= r;
				neg_s[i+1] <= neg_s[i];
				kind_s[i+1] <= kind_s[i];
				ok_s[i+1] <= ok_s[i];
				u1_s[i+1] <= u1_s[i];
				u2_s[i+1] <= u2_s[i];
			end
		end
	end
	logic [QW:0] mag;
	logic signed [QW+1:0] rr;
	logic signed [UF+2:0] rc;
	always_comb begin
		mag = {1'b0, quo_s[LAT]} + ((neg_s[LAT] && rem_s[LAT] != '0) ? (QW+1)'(1) : '0);
		rr = neg_s[LAT] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (rr < -(QW+2)'(ONE)) rc = -ONE;
		else if (rr > (QW+2)'(ONE) * 2) rc = ONE <<< 1;
		else rc = rr[UF+2:0];
		out_ok = ok_s[LAT];
		out_u1 = u1_s[LAT];
		out_u2 = u2_s[LAT];
		case (kind_s[LAT])
			KIND_ENTER: begin
				if (rc > u2_s[LAT]) out_ok = 1'b0;
				else if (rc > u1_s[LAT]) out_u1 = rc;
			end
			KIND_EXIT: begin
				if (rc < u1_s[LAT]) out_ok = 1'b0;
				else if (rc < u2_s[LAT]) out_u2 = rc;
			end
			KIND_REJECT: out_ok = 1'b0;
			default: ;
		endcase
	end
endmodule

// ===== rtl/lbc_point_cell.sv =====
// Output cell: multiplies u by the deltas and rounds to the output fixed point.
// Depends on lbc_pkg.
module lbc_point_cell #(
	parameter int CW = 16,
	parameter int UF = 16,
	parameter int OF = 4
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [UF+2:0] u,
	input  logic                 move,
	input  logic signed [CW-1:0] base,
	input  logic signed [CW-1:0] alt,
	input  logic signed [CW:0]   dx,
	input  logic signed [CW:0]   dy,
	input  logic signed [CW-1:0] base_y,
	input  logic signed [CW-1:0] alt_y,
	output logic signed [19:0]   px,
	output logic signed [19:0]   py
);
	import lbc_pkg::*;
	localparam int PW = UF + CW + 4;
	localparam int SH = UF - OF;
	logic signed [PW-1:0] mx_s1, my_s1;
	logic mv_s1;
	logic signed [CW-1:0] bx_s1, by_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= PW'(u) * PW'(dx);
			my_s1 <= PW'(u) * PW'(dy);
			mv_s1 <= move;
			bx_s1 <= move ? base : alt;
			by_s1 <= move ? base_y : alt_y;
		end
	end
	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
		if (SH <= 0) return v <<< (-SH);
		return (v + (PW'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
	endfunction
	always_comb begin
		px = OUT_W'((PW'(bx_s1) <<< OF) + (mv_s1 ? rnd(mx_s1) : '0));
		py = OUT_W'((PW'(by_s1) <<< OF) + (mv_s1 ? rnd(my_s1) : '0));
	end
endmodule

// ===== rtl/liang_barsky_line_clip.sv =====
// Liang-Barsky clipper top level: config registers, a row of edge cells (one per window edge), output cells.
// One segment per cycle, while the output register is empty or being taken.
// Each edge cell holds a pipelined divider, one quotient slice per stage.
// The whole row advances when the output register is empty or being taken.
// Reset clears valid flags and loads the default window 0,0 to 799,599.
module liang_barsky_line_clip #(
	parameter int COORD_BITS = 16,
	parameter int U_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata, // start_x, start_y, end_x, end_y
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata, // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import lbc_pkg::*;
	localparam int CW = COORD_BITS;
	localparam int UF = U_FRAC_BITS;
	localparam int LAT = CW + UF + 3;
	localparam int TOT = 4 * LAT;
	localparam logic signed [UF+2:0] ONE = (UF+3)'(1) <<< UF;
	logic [15:0] wmin_x_q, wmin_y_q, wmax_x_q, wmax_y_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmin_x_q <= '0; wmin_y_q <= '0;
			wmax_x_q <= 16'd799; wmax_y_q <= 16'd599;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_X: wmin_x_q <= cfg_data;
				REG_MIN_Y: wmin_y_q <= cfg_data;
				REG_MAX_X: wmax_x_q <= cfg_data;
				REG_MAX_Y: wmax_y_q <= cfg_data;
				default: ;
			endcase
		end
	end
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	logic signed [CW-1:0] x0, y0, x1, y1, xmn, ymn, xmx, ymx;
	assign x0 = s_tdata[CW-1:0];
	assign y0 = s_tdata[16+CW-1:16];
	assign x1 = s_tdata[32+CW-1:32];
	assign y1 = s_tdata[48+CW-1:48];
	assign xmn = wmin_x_q[CW-1:0];
	assign ymn = wmin_y_q[CW-1:0];
	assign xmx = wmax_x_q[CW-1:0];
	assign ymx = wmax_y_q[CW-1:0];
	// Registered entry stage with p/q terms for every window edge.
	logic signed [CW+1:0] p_s1 [0:3];
	logic signed [CW+1:0] q_s1 [0:3];
	logic signed [CW-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic v_s1;
	logic signed [CW+1:0] dxe, dye;
	assign dxe = (CW+2)'(x1) - (CW+2)'(x0);
	assign dye = (CW+2)'(y1) - (CW+2)'(y0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= -dxe; q_s1[0] <= (CW+2)'(x0) - (CW+2)'(xmn);
			p_s1[1] <= dxe;  q_s1[1] <= (CW+2)'(xmx) - (CW+2)'(x0);
			p_s1[2] <= -dye; q_s1[2] <= (CW+2)'(y0) - (CW+2)'(ymn);
			p_s1[3] <= dye;  q_s1[3] <= (CW+2)'(ymx) - (CW+2)'(y0);
			x0_s1 <= x0; y0_s1 <= y0; x1_s1 <= x1; y1_s1 <= y1;
		end
	end
	// Delay lines so each cell sees its p/q when its bounds arrive.
	logic signed [CW+1:0] pd [0:3][0:3*LAT];
	logic signed [CW+1:0] qd [0:3][0:3*LAT];
	logic signed [CW-1:0] cd [0:3][0:TOT];
	logic vd [0:TOT];
	assign cd[0][0] = x0_s1;
	assign cd[1][0] = y0_s1;
	assign cd[2][0] = x1_s1;
	assign cd[3][0] = y1_s1;
	assign vd[0] = v_s1;
	for (genvar e = 0; e < 4; e++) begin : g_pqe
		assign pd[e][0] = p_s1[e];
		assign qd[e][0] = q_s1[e];
		for (genvar k = 0; k < e * LAT; k++) begin : g_pq
			always_ff @(posedge clk) begin
				if (en) begin
					pd[e][k+1] <= pd[e][k];
					qd[e][k+1] <= qd[e][k];
				end
			end
		end
		for (genvar k = 0; k < TOT; k++) begin : g_cd
			always_ff @(posedge clk) begin
				if (en) cd[e][k+1] <= cd[e][k];
			end
		end
	end
	for (genvar k = 0; k < TOT; k++) begin : g_vd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd[k+1] <= 1'b0;
			else if (en) vd[k+1] <= vd[k];
		end
	end
	logic ok [0:4];
	logic signed [UF+2:0] u1 [0:4];
	logic signed [UF+2:0] u2 [0:4];
	assign ok[0] = 1'b1;
	assign u1[0] = '0;
	assign u2[0] = ONE;
	for (genvar e = 0; e < 4; e++) begin : g_cell
		lbc_edge_cell #(.CW(CW), .UF(UF), .LAT(LAT)) u_cell (
			.clk(clk), .en(en),
			.p(pd[e][e*LAT]), .q(qd[e][e*LAT]),
			.in_ok(ok[e]), .in_u1(u1[e]), .in_u2(u2[e]),
			.out_ok(ok[e+1]), .out_u1(u1[e+1]), .out_u2(u2[e+1])
		);
	end
	logic signed [CW:0] dx, dy;
	assign dx = (CW+1)'(cd[2][TOT]) - (CW+1)'(cd[0][TOT]);
	assign dy = (CW+1)'(cd[3][TOT]) - (CW+1)'(cd[1][TOT]);
	logic signed [19:0] sx, sy, ex, ey;
	logic ok_s2, v_s2;
	lbc_point_cell #(.CW(CW), .UF(UF), .OF(OUT_FRAC_BITS)) u_start (
		.clk(clk), .en(en), .u(u1[4]), .move(u1[4] > 0),
		.base(cd[0][TOT]), .alt(cd[0][TOT]), .dx(dx), .dy(dy),
		.base_y(cd[1][TOT]), .alt_y(cd[1][TOT]), .px(sx), .py(sy)
	);
	lbc_point_cell #(.CW(CW), .UF(UF), .OF(OUT_FRAC_BITS)) u_end (
		.clk(clk), .en(en), .u(u2[4]), .move(u2[4] < ONE),
		.base(cd[0][TOT]), .alt(cd[2][TOT]), .dx(dx), .dy(dy),
		.base_y(cd[1][TOT]), .alt_y(cd[3][TOT]), .px(ex), .py(ey)
	);
	always_ff @(posedge clk) begin
		if (en) ok_s2 <= ok[4];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= vd[TOT];
	end
	assign m_tvalid = v_s2;
	always_comb begin
		m_tdata = '0;
		if (ok_s2) m_tdata[80:0] = {ey, ex, sy, sx, 1'b1};
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready));
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[80:1] == '0);
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tdata[87:81] == '0);
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for liang_barsky_line_clip: streams segments through the clipper
// under several clip windows and compares every beat with a built-in clipper model.
// Depends on rtl/lbc_pkg.sv and rtl/liang_barsky_line_clip.sv.
module tb;
	import lbc_pkg::*;

	typedef struct {
		logic signed [15:0] sx, sy, ex, ey;
	} seg_t;

	typedef struct {
		logic        vis;
		logic [19:0] sx, sy, ex, ey;
	} clip_t;

	localparam longint U_ONE = 64'sd65536;
	localparam int PIPE_CYCLES = 4 * (16 + 16 + 3) + 2;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	seg_t  seg_pending[$];
	clip_t clip_expected[$];
	logic signed [15:0] win_min_x, win_min_y, win_max_x, win_max_y;
	int    fail_count;
	logic  in_beat, out_beat;
	int    send_gap, recv_stall, hold_left, out_count;
	bit    held_once;

	liang_barsky_line_clip u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8ns * 3000000);
		$display("liang_barsky_line_clip test failed");
		$finish;
	end

	function automatic longint floor_quot(longint n, longint d);
		if (n >= 0) begin
			return n / d;
		end
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint edge_ratio(longint q, longint p);
		longint n, d, r;
		n = q * U_ONE;
		d = p;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		r = floor_quot(n, d);
		if (r < -U_ONE) r = -U_ONE;
		if (r > 2 * U_ONE) r = 2 * U_ONE;
		return r;
	endfunction

	function automatic bit edge_pass(longint p, longint q, inout longint u_in, inout longint u_out);
		longint r;
		if (p < 0) begin
			r = edge_ratio(q, p);
			if (r > u_out) return 1'b0;
			if (r > u_in) u_in = r;
		end else if (p > 0) begin
			r = edge_ratio(q, p);
			if (r < u_in) return 1'b0;
			if (r < u_out) u_out = r;
		end else if (q < 0) begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [19:0] fixed_point_at(longint base, longint u, longint delta);
		longint v;
		v = base * 16 + floor_quot(u * delta + 2048, 4096);
		return v[19:0];
	endfunction

	function automatic clip_t clip_segment(seg_t s);
		clip_t  c;
		longint x0, y0, x1, y1, dx, dy, u_in, u_out;
		bit     ok;
		x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
		dx = x1 - x0;
		dy = y1 - y0;
		u_in = 0;
		u_out = U_ONE;
		ok = edge_pass(-dx, x0 - longint'(win_min_x), u_in, u_out);
		if (ok) ok = edge_pass(dx, longint'(win_max_x) - x0, u_in, u_out);
		if (ok) ok = edge_pass(-dy, y0 - longint'(win_min_y), u_in, u_out);
		if (ok) ok = edge_pass(dy, longint'(win_max_y) - y0, u_in, u_out);
		c = '{vis: 1'b0, sx: '0, sy: '0, ex: '0, ey: '0};
		if (ok) begin
			c.vis = 1'b1;
			c.sx = fixed_point_at(x0, (u_in > 0) ? u_in : 0, dx);
			c.sy = fixed_point_at(y0, (u_in > 0) ? u_in : 0, dy);
			if (u_out < U_ONE) begin
				c.ex = fixed_point_at(x0, u_out, dx);
				c.ey = fixed_point_at(y0, u_out, dy);
			end else begin
				c.ex = fixed_point_at(x1, 0, 0);
				c.ey = fixed_point_at(y1, 0, 0);
			end
		end
		return c;
	endfunction

	// Sender: draws a gap before each beat and holds the beat until it is taken.
	always @(negedge clk) begin
		seg_t s;
		if (arst_n && (!s_tvalid || in_beat)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (seg_pending.size() > 0) begin
				s = seg_pending.pop_front();
				s_tdata <= {s.ey, s.ex, s.sy, s.sx};
				s_tvalid <= 1'b1;
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls per beat, plus one long hold-off that stalls the whole pipeline.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_once && out_count == 60) begin
				held_once <= 1'b1;
				hold_left <= 2000;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (out_beat) begin
				if ($urandom_range(0, 3) == 0) begin
					recv_stall <= 0;
					m_tready <= 1'b1;
				end else begin
					recv_stall <= $urandom_range(0, 10);
					m_tready <= 1'b0;
				end
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		seg_t  s;
		clip_t got, want;
		in_beat <= s_tvalid && s_tready;
		out_beat <= m_tvalid && m_tready;
		if (s_tvalid && s_tready) begin
			s = '{sx: s_tdata[15:0], sy: s_tdata[31:16], ex: s_tdata[47:32], ey: s_tdata[63:48]};
			clip_expected.push_back(clip_segment(s));
		end
		if (m_tvalid && m_tready) begin
			out_count <= out_count + 1;
			got = '{vis: m_tdata[0], sx: m_tdata[20:1], sy: m_tdata[40:21],
				ex: m_tdata[60:41], ey: m_tdata[80:61]};
			if (clip_expected.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				want = clip_expected.pop_front();
				if (got.vis !== want.vis) begin
					$error("visible: expected %0d, got %0d", want.vis, got.vis);
					fail_count++;
				end
				if (got.sx !== want.sx) begin
					$error("clip_start_x: expected %0h, got %0h", want.sx, got.sx);
					fail_count++;
				end
				if (got.sy !== want.sy) begin
					$error("clip_start_y: expected %0h, got %0h", want.sy, got.sy);
					fail_count++;
				end
				if (got.ex !== want.ex) begin
					$error("clip_end_x: expected %0h, got %0h", want.ex, got.ex);
					fail_count++;
				end
				if (got.ey !== want.ey) begin
					$error("clip_end_y: expected %0h, got %0h", want.ey, got.ey);
					fail_count++;
				end
			end
		end
	end

	task automatic add_seg(int sx, int sy, int ex, int ey);
		seg_pending.push_back('{sx: sx[15:0], sy: sy[15:0], ex: ex[15:0], ey: ey[15:0]});
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_X: win_min_x = val;
			REG_MIN_Y: win_min_y = val;
			REG_MAX_X: win_max_x = val;
			default:   win_max_y = val;
		endcase
	endtask

	task automatic set_window(int x0, int y0, int x1, int y1);
		write_reg(REG_MIN_X, x0[15:0]);
		write_reg(REG_MIN_Y, y0[15:0]);
		write_reg(REG_MAX_X, x1[15:0]);
		write_reg(REG_MAX_Y, y1[15:0]);
	endtask

	task automatic drain();
		while (seg_pending.size() > 0 || s_tvalid || clip_expected.size() > 0) begin
			@(posedge clk);
		end
		repeat (PIPE_CYCLES + 10) @(posedge clk);
	endtask

	function automatic int near_coord(int lo, int hi);
		int v;
		if (hi < lo || $urandom_range(0, 4) == 0) begin
			return int'($urandom_range(0, 65535)) - 32768;
		end
		v = lo - 64 + int'($urandom_range(0, hi - lo + 128));
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		return v;
	endfunction

	task automatic add_random(int n);
		int x0, y0;
		for (int i = 0; i < n; i++) begin
			x0 = near_coord(win_min_x, win_max_x);
			y0 = near_coord(win_min_y, win_max_y);
			case ($urandom_range(0, 5))
				0: add_seg(x0, y0, x0, y0);
				1: add_seg(x0, y0, x0, near_coord(win_min_y, win_max_y));
				2: add_seg(x0, y0, near_coord(win_min_x, win_max_x), y0);
				default: add_seg(x0, y0, near_coord(win_min_x, win_max_x),
					near_coord(win_min_y, win_max_y));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_X;
		cfg_data = '0;
		fail_count = 0;
		in_beat = 1'b0;
		out_beat = 1'b0;
		send_gap = 0;
		recv_stall = 0;
		hold_left = 0;
		out_count = 0;
		held_once = 1'b0;
		win_min_x = 16'sd0;
		win_min_y = 16'sd0;
		win_max_x = 16'sd799;
		win_max_y = 16'sd599;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_seg(100, 100, 200, 200);
		add_seg(-100, 300, 900, 300);
		add_seg(400, -50, 400, 700);
		add_seg(-10, -10, -5, -5);
		add_seg(900, 100, 1000, 500);
		add_seg(100, 700, 200, 800);
		add_seg(-50, 10, -50, 500);
		add_seg(300, 300, 300, 300);
		add_seg(0, 0, 0, 0);
		add_seg(800, 600, 800, 600);
		add_seg(-10, 10, 10, -10);
		add_seg(789, 609, 809, 589);
		add_seg(-32768, -32768, 32767, 32767);
		add_seg(32767, -32768, -32768, 32767);
		add_seg(799, 599, -32768, -32768);
		add_seg(0, 599, 799, 0);
		add_seg(-32768, 0, -32768, 0);
		add_seg(850, 300, -3, 7);
		add_random(150);
		drain();

		set_window(-32768, -32768, 32767, 32767);
		add_seg(-32768, -32768, 32767, 32767);
		add_seg(32767, 32767, -32768, -32768);
		add_random(100);
		drain();

		set_window(500, 500, -500, -500);
		add_seg(0, 0, 0, 0);
		add_random(60);
		drain();

		set_window(5, 5, 6, 6);
		add_seg(0, 0, 11, 11);
		add_seg(5, 0, 5, 20);
		add_random(100);
		drain();

		set_window(32767, -32768, 32767, -32768);
		add_seg(32767, -32768, 32767, -32768);
		add_random(50);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			int a, b, c, d;
			a = int'($urandom_range(0, 65535)) - 32768;
			b = int'($urandom_range(0, 65535)) - 32768;
			c = int'($urandom_range(0, 65535)) - 32768;
			d = int'($urandom_range(0, 65535)) - 32768;
			if ($urandom_range(0, 3) != 0) begin
				set_window((a < c) ? a : c, (b < d) ? b : d, (a < c) ? c : a, (b < d) ? d : b);
			end else begin
				set_window(a, b, c, d);
			end
			add_random(110);
			drain();
		end

		if (fail_count == 0) begin
			$display("liang_barsky_line_clip test passed");
		end else begin
			$display("liang_barsky_line_clip test failed");
		end
		$finish;
	end
endmodule

// ===== liang_barsky_line_clip.f =====
rtl/lbc_pkg.sv
rtl/lbc_edge_cell.sv
rtl/lbc_point_cell.sv
rtl/liang_barsky_line_clip.sv
bench/tb.sv
